/* sv/sorf_pkg.sv */
// Package for the scan result output formatter.
// Holds field widths, format and status codes, register indices and shared types.
// Has no dependencies.
`default_nettype none

package sorf_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 3;
  localparam int STATUS_W = 2;
  localparam int FMT_W    = 2;
  localparam int ADDR_W   = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [FMT_W-1:0] FMT_PACKED = 2'd0;
  localparam logic [FMT_W-1:0] FMT_IDX8   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_IDX16  = 2'd2;
  localparam logic [FMT_W-1:0] FMT_IDX32  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_IDX_OVF   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEST_FULL = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_FMT_SEL       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BIG_ENDIAN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEST_CAPACITY = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0]   out_data;
    logic [COUNT_W-1:0]  out_byte_count;
    logic [STATUS_W-1:0] status;
    logic                end_of_run;
  } result_t;

endpackage

`default_nettype wire

/* sv/sorf_ifs.sv */
// Valid/ready channel interfaces for the scan result output formatter.
// The input channel carries one element beat, the output channel one result beat.
// Depends on sorf_pkg.
`default_nettype none

interface sorf_in_if;
  logic valid;
  logic ready;
  logic match_bit;
  logic last_element;

  modport source (output valid, output match_bit, output last_element, input ready);
  modport sink (input valid, input match_bit, input last_element, output ready);
endinterface

interface sorf_out_if
  import sorf_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   out_data;
  logic [COUNT_W-1:0]  out_byte_count;
  logic [STATUS_W-1:0] status;
  logic                end_of_run;

  modport source (output valid, output out_data, output out_byte_count, output status,
                  output end_of_run, input ready);
  modport sink (input valid, input out_data, input out_byte_count, input status,
                input end_of_run, output ready);
endinterface

`default_nettype wire

/* sv/scan_result_output_formatter_top.sv */
// Scan result output formatter, top level with APB register port.
// A result beat is registered: it is valid in the cycle after the element beat that causes it.
// Throughput: one element beat per cycle while the receiver takes every result beat.
// A result beat that waits stalls the input.
// Reset (rst, synchronous) clears the registers, the run state and the output valid.
// Depends on sorf_pkg and sorf_ifs.
`default_nettype none

module scan_result_output_formatter_top
  import sorf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  sorf_in_if.sink                din,
  sorf_out_if.source             dout,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [FMT_W-1:0]    fmt_sel;
  logic                big_endian;
  logic [31:0]         dest_capacity;

  logic [31:0]         element_index;
  logic [31:0]         bytes_written;
  logic [7:0]          bit_accumulator;
  logic                error_latched;
  logic [STATUS_W-1:0] held_code;

  logic [31:0]         element_index_next;
  logic [31:0]         bytes_written_next;
  logic [7:0]          bit_accumulator_next;
  logic                error_latched_next;
  logic [STATUS_W-1:0] held_code_next;

  logic                out_valid;
  result_t             result;
  result_t             result_next;
  logic                emit;

  logic                in_acc;
  logic                cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic [2:0]          pos;
  logic [7:0]          bit_mask;
  logic [7:0]          acc_new;
  logic [COUNT_W-1:0]  width_bytes;
  logic                idx_over;
  logic                cap_over;
  logic [32:0]         cap_sum;
  logic [DATA_W-1:0]   idx_data;
  logic [31:0]         idx_plus;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_FMT_SEL:       prdata = {30'd0, fmt_sel};
      REG_BIG_ENDIAN:    prdata = {31'd0, big_endian};
      REG_DEST_CAPACITY: prdata = dest_capacity;
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_sel       <= FMT_PACKED;
      big_endian    <= 1'b0;
      dest_capacity <= 32'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FMT_SEL:       fmt_sel       <= pwdata[FMT_W-1:0];
        REG_BIG_ENDIAN:    big_endian    <= pwdata[0];
        REG_DEST_CAPACITY: dest_capacity <= pwdata;
        default: ;
      endcase
    end
  end

  assign din.ready = !out_valid || dout.ready;
  assign in_acc    = din.valid && din.ready;

  assign pos      = element_index[2:0];
  assign bit_mask = big_endian ? (8'h80 >> pos) : (8'h01 << pos);
  assign acc_new  = din.match_bit ? (bit_accumulator | bit_mask) : bit_accumulator;
  assign idx_plus = element_index + 32'd1;

  always_comb begin
    case (fmt_sel)
      FMT_IDX8: begin
        width_bytes = 3'd1;
        idx_over    = |element_index[31:8];
        idx_data    = {24'd0, element_index[7:0]};
      end
      FMT_IDX16: begin
        width_bytes = 3'd2;
        idx_over    = |element_index[31:16];
        idx_data    = big_endian ? {16'd0, element_index[7:0], element_index[15:8]}
                                 : {16'd0, element_index[15:0]};
      end
      default: begin
        width_bytes = 3'd4;
        idx_over    = 1'b0;
        idx_data    = big_endian ? {element_index[7:0], element_index[15:8],
                                    element_index[23:16], element_index[31:24]}
                                 : element_index;
      end
    endcase
  end

  assign cap_sum  = {1'b0, bytes_written} + {30'd0, width_bytes};
  assign cap_over = cap_sum > {1'b0, dest_capacity};

  always_comb begin
    element_index_next   = element_index;
    bytes_written_next   = bytes_written;
    bit_accumulator_next = bit_accumulator;
    error_latched_next   = error_latched;
    held_code_next       = held_code;
    result_next.out_data       = '0;
    result_next.out_byte_count = '0;
    result_next.status         = STATUS_OK;
    result_next.end_of_run     = din.last_element;
    emit = 1'b0;

    if (error_latched) begin
      result_next.status = held_code;
      emit = din.last_element;
    end else if (fmt_sel == FMT_PACKED) begin
      element_index_next   = idx_plus;
      bit_accumulator_next = acc_new;
      if (pos == 3'd7 || din.last_element) begin
        result_next.out_data       = {24'd0, acc_new};
        result_next.out_byte_count = 3'd1;
        bytes_written_next         = bytes_written + 32'd1;
        bit_accumulator_next       = 8'd0;
        emit = 1'b1;
      end
    end else begin
      if (din.match_bit) begin
        if (idx_over) begin
          result_next.status = STATUS_IDX_OVF;
        end else if (cap_over) begin
          result_next.status = STATUS_DEST_FULL;
        end else begin
          result_next.out_data       = idx_data;
          result_next.out_byte_count = width_bytes;
          bytes_written_next         = cap_sum[31:0];
        end
      end
      if (result_next.status == STATUS_OK) begin
        if (fmt_sel == FMT_IDX32 && (&element_index)) begin
          result_next.status = STATUS_IDX_OVF;
        end else begin
          element_index_next = idx_plus;
        end
      end
      if (result_next.status != STATUS_OK) begin
        error_latched_next = 1'b1;
        held_code_next     = result_next.status;
      end
      emit = (result_next.out_byte_count != 3'd0) || (result_next.status != STATUS_OK)
             || din.last_element;
    end

    if (din.last_element) begin
      element_index_next   = 32'd0;
      bytes_written_next   = 32'd0;
      bit_accumulator_next = 8'd0;
      error_latched_next   = 1'b0;
      held_code_next       = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index   <= 32'd0;
      bytes_written   <= 32'd0;
      bit_accumulator <= 8'd0;
      error_latched   <= 1'b0;
      held_code       <= STATUS_OK;
      out_valid       <= 1'b0;
    end else begin
      if (in_acc) begin
        element_index   <= element_index_next;
        bytes_written   <= bytes_written_next;
        bit_accumulator <= bit_accumulator_next;
        error_latched   <= error_latched_next;
        held_code       <= held_code_next;
      end
      if (in_acc && emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      result <= result_next;
    end
  end

  assign dout.valid          = out_valid;
  assign dout.out_data       = result.out_data;
  assign dout.out_byte_count = result.out_byte_count;
  assign dout.status         = result.status;
  assign dout.end_of_run     = result.end_of_run;

  // A held error swallows every element but the last one.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && error_latched && !din.last_element) |-> !emit)
    else $error("element produced a beat while an error was held");

  // An empty result beat only reports the end of a run or an error.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.out_byte_count == 3'd0) |->
      (result.end_of_run || result.status != STATUS_OK))
    else $error("empty result beat without end of run or error");

  // The last element returns the run state to its starting point.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && din.last_element) |=>
      (element_index == 32'd0 && bytes_written == 32'd0 && !error_latched
       && bit_accumulator == 8'd0))
    else $error("run state not cleared after the last element");

  // An error code is never held without the error flag.
  assert property (@(posedge clk) disable iff (rst)
    (held_code != STATUS_OK) |-> error_latched)
    else $error("held error code without latched error");

endmodule

`default_nettype wire

/* sim/scan_result_output_formatter_top_test.sv */
// Self-checking testbench for the scan result output formatter top level.
// Drives element beats and APB register writes, predicts every result beat and compares them.
// Depends on sorf_pkg, sorf_ifs and scan_result_output_formatter_top.
`default_nettype none

module scan_result_output_formatter_top_test;
  import sorf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] CAP_MAX     = 32'hFFFF_FFFF;
  localparam int          HOLD_CYCLES = 80;
  localparam int          RAND_ITEMS  = 480;
  localparam int          DIR_ROWS    = 25;
  localparam result_t     NO_RESULT   = '0;

  typedef struct {
    logic [FMT_W-1:0] fmt;
    bit               be;
    logic [31:0]      cap;
    bit               hit;
    bit               fin;
    bit               typed;
    result_t          res;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  sorf_in_if  din_if ();
  sorf_out_if dout_if ();

  scan_result_output_formatter_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [FMT_W-1:0]    cfg_fmt;
  bit                  cfg_be;
  logic [31:0]         cfg_cap;
  logic [31:0]         elem_idx;
  logic [31:0]         bytes_out;
  logic [7:0]          pack_byte;
  bit                  err_held;
  logic [STATUS_W-1:0] err_code;

  result_t expected_beats[$];
  int      fail_count;
  int      elems_sent;
  int      beats_seen;
  int      reg_writes;
  bit      send_gaps;
  bit      hold_req;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b1, 1'b1, '{32'h01, 3'd1, STATUS_OK, 1'b1}},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1, '{32'hFF, 3'd1, STATUS_OK, 1'b0}},
    '{FMT_PACKED, 1'b0, 32'd0, 1'b0, 1'b1, 1'b1, '{32'h00, 3'd1, STATUS_OK, 1'b1}},
    '{FMT_PACKED, 1'b1, 32'd0, 1'b1, 1'b1, 1'b1, '{32'h80, 3'd1, STATUS_OK, 1'b1}},
    '{FMT_IDX8,   1'b0, 32'd0, 1'b1, 1'b0, 1'b1, '{32'h0, 3'd0, STATUS_DEST_FULL, 1'b0}},
    '{FMT_IDX8,   1'b0, 32'd0, 1'b1, 1'b1, 1'b1, '{32'h0, 3'd0, STATUS_DEST_FULL, 1'b1}},
    '{FMT_IDX8,   1'b0, CAP_MAX, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX8,   1'b0, CAP_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX8,   1'b0, CAP_MAX, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{FMT_IDX16,  1'b1, CAP_MAX, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX16,  1'b1, CAP_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX16,  1'b1, CAP_MAX, 1'b0, 1'b1, 1'b1, '{32'h0, 3'd0, STATUS_OK, 1'b1}},
    '{FMT_IDX32,  1'b0, 32'd4, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX32,  1'b0, 32'd4, 1'b1, 1'b1, 1'b1, '{32'h0, 3'd0, STATUS_DEST_FULL, 1'b1}},
    '{FMT_IDX32,  1'b1, CAP_MAX, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX32,  1'b1, CAP_MAX, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{FMT_IDX16,  1'b0, 32'd2, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{FMT_IDX16,  1'b0, 32'd2, 1'b1, 1'b1, 1'b1, '{32'h0, 3'd0, STATUS_DEST_FULL, 1'b1}}
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] to_big_endian(logic [31:0] v, int unsigned nbytes);
    case (nbytes)
      2:       return {16'h0, v[7:0], v[15:8]};
      4:       return {v[7:0], v[15:8], v[23:16], v[31:24]};
      default: return {24'h0, v[7:0]};
    endcase
  endfunction

  task automatic clear_run_state();
    elem_idx  = '0;
    bytes_out = '0;
    pack_byte = '0;
    err_held  = 1'b0;
    err_code  = STATUS_OK;
  endtask

  task automatic format_element(input bit hit, input bit fin, output bit emit,
                                output result_t r);
    logic [2:0]          pos;
    logic [7:0]          mask;
    int unsigned         nbytes;
    logic [31:0]         lim;
    logic [31:0]         v;
    logic [STATUS_W-1:0] st;
    r    = NO_RESULT;
    emit = 1'b0;
    st   = STATUS_OK;
    if (err_held) begin
      r.status = err_code;
      emit     = fin;
    end else if (cfg_fmt == FMT_PACKED) begin
      pos  = elem_idx[2:0];
      mask = cfg_be ? (8'h80 >> pos) : (8'h01 << pos);
      if (hit) begin
        pack_byte = pack_byte | mask;
      end
      elem_idx = elem_idx + 1;
      if (pos == 3'd7 || fin) begin
        r.out_data       = {24'h0, pack_byte};
        r.out_byte_count = 3'd1;
        bytes_out        = bytes_out + 1;
        pack_byte        = '0;
        emit             = 1'b1;
      end
    end else begin
      case (cfg_fmt)
        FMT_IDX8:  nbytes = 1;
        FMT_IDX16: nbytes = 2;
        default:   nbytes = 4;
      endcase
      lim = (cfg_fmt == FMT_IDX8) ? 32'd255 : 32'd65535;
      if (hit) begin
        if (cfg_fmt != FMT_IDX32 && elem_idx > lim) begin
          st = STATUS_IDX_OVF;
        end else if (({1'b0, bytes_out} + 33'(nbytes)) > {1'b0, cfg_cap}) begin
          st = STATUS_DEST_FULL;
        end else begin
          if (nbytes == 1) begin
            v = {24'h0, elem_idx[7:0]};
          end else if (nbytes == 2) begin
            v = {16'h0, elem_idx[15:0]};
          end else begin
            v = elem_idx;
          end
          r.out_data       = cfg_be ? to_big_endian(v, nbytes) : v;
          r.out_byte_count = COUNT_W'(nbytes);
          bytes_out        = bytes_out + nbytes;
        end
      end
      if (st == STATUS_OK) begin
        if (cfg_fmt == FMT_IDX32 && elem_idx == 32'hFFFF_FFFF) begin
          st = STATUS_IDX_OVF;
        end else begin
          elem_idx = elem_idx + 1;
        end
      end
      if (st != STATUS_OK) begin
        err_held = 1'b1;
        err_code = st;
      end
      r.status = st;
      emit     = (r.out_byte_count != 0) || (st != STATUS_OK) || fin;
    end
    r.end_of_run = fin;
    if (fin) begin
      clear_run_state();
    end
  endtask

  task automatic send_elem(input bit hit, input bit fin, input bit typed, input result_t typed_res);
    int      gap;
    bit      emit;
    result_t r;
    gap = send_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid        <= 1'b1;
    din_if.match_bit    <= hit;
    din_if.last_element <= fin;
    do @(posedge clk); while (!din_if.ready);
    elems_sent++;
    format_element(hit, fin, emit, r);
    if (typed) begin
      expected_beats.push_back(typed_res);
    end else if (emit) begin
      expected_beats.push_back(r);
    end
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_writes++;
    case (idx)
      REG_FMT_SEL:       cfg_fmt = val[FMT_W-1:0];
      REG_BIG_ENDIAN:    cfg_be  = val[0];
      REG_DEST_CAPACITY: cfg_cap = val;
      default: ;
    endcase
  endtask

  task automatic reg_read(input logic [REG_IDX_W-1:0] idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
  endtask

  task automatic set_config(input logic [FMT_W-1:0] fmt, input bit be, input logic [31:0] cap);
    logic [REG_IDX_W-1:0] reg_ids [3];
    logic [31:0]          reg_vals [3];
    logic [31:0]          rd;
    reg_ids  = '{REG_FMT_SEL, REG_BIG_ENDIAN, REG_DEST_CAPACITY};
    reg_vals = '{32'(fmt), 32'(be), cap};
    din_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      reg_write(reg_ids[i], reg_vals[i]);
    end
    for (int i = 0; i < 3; i++) begin
      reg_read(reg_ids[i], rd);
      if (rd !== reg_vals[i]) begin
        $display("%0t: register %0d read back mismatch: expected %h, got %h",
                 $time, reg_ids[i], reg_vals[i], rd);
        fail_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic index_overflow_run(input logic [FMT_W-1:0] fmt, input bit be);
    int unsigned top;
    top = (fmt == FMT_IDX8) ? 255 : 65535;
    set_config(fmt, be, CAP_MAX);
    for (int unsigned i = 0; i < top; i++) begin
      send_elem(1'b0, 1'b0, 1'b0, NO_RESULT);
    end
    send_elem(1'b1, 1'b0, 1'b0, NO_RESULT);
    send_elem(1'b1, 1'b0, 1'b0, NO_RESULT);
    send_elem(1'b0, 1'b1, 1'b0, NO_RESULT);
  endtask

  task automatic random_phase();
    logic [FMT_W-1:0] fmt;
    bit               be;
    logic [31:0]      cap;
    int unsigned      len;
    int unsigned      pct;
    bit               hit;
    bit               fin;
    fmt = FMT_W'($urandom_range(0, 3));
    be  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       cap = '0;
      1:       cap = CAP_MAX;
      2, 3:    cap = $urandom;
      default: cap = $urandom_range(0, 48);
    endcase
    set_config(fmt, be, cap);
    pct = 10 + 40 * $urandom_range(0, 2);
    len = $urandom_range(1, 24);
    if (fmt == FMT_IDX8 && $urandom_range(0, 5) == 0) begin
      len = $urandom_range(250, 300);
    end
    for (int unsigned i = 0; i < len; i++) begin
      hit = ($urandom_range(0, 99) < pct);
      fin = (i == len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0);
      send_elem(hit, fin, 1'b0, NO_RESULT);
    end
  endtask

  initial begin : result_sink
    int      stall;
    result_t got;
    result_t want;
    dout_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 5);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      @(posedge clk);
      while (!dout_if.valid) @(posedge clk);
      got = '{dout_if.out_data, dout_if.out_byte_count, dout_if.status, dout_if.end_of_run};
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: got data=%h count=%0d status=%0d end=%0d",
                 $time, got.out_data, got.out_byte_count, got.status, got.end_of_run);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                   $time, want.out_data, want.out_byte_count, want.status, want.end_of_run,
                   got.out_data, got.out_byte_count, got.status, got.end_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int base;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    din_if.valid        <= 1'b0;
    din_if.match_bit    <= 1'b0;
    din_if.last_element <= 1'b0;
    fail_count = 0;
    elems_sent = 0;
    beats_seen = 0;
    reg_writes = 0;
    send_gaps  = 1'b1;
    hold_req   = 1'b0;
    cfg_fmt    = FMT_PACKED;
    cfg_be     = 1'b0;
    cfg_cap    = '0;
    clear_run_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].fmt != cfg_fmt || dir_rows[i].be != cfg_be
          || dir_rows[i].cap != cfg_cap) begin
        set_config(dir_rows[i].fmt, dir_rows[i].be, dir_rows[i].cap);
      end
      send_elem(dir_rows[i].hit, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].res);
    end

    index_overflow_run(FMT_IDX8, 1'b0);
    send_gaps = 1'b0;

    set_config(FMT_IDX8, 1'b0, CAP_MAX);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_elem(1'b1, i == 39, 1'b0, NO_RESULT);
    end
    send_gaps = 1'b1;

    base = elems_sent;
    while (elems_sent - base < RAND_ITEMS) begin
      random_phase();
    end

    din_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Summary: %0d element beats sent, %0d result beats checked, %0d register writes.",
             elems_sent, beats_seen, reg_writes);
    $display("Covered packed and index forms, both byte orders, capacity and index limits.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/sorf_pkg.sv
sv/sorf_ifs.sv
sv/scan_result_output_formatter_top.sv
sim/scan_result_output_formatter_top_test.sv
